// ===== src/ptt_pkg.sv =====
// Package for the periodic task timer table.
// Holds the table size, derived widths, command codes, controller states and the
// command and status structs that join the controller to the datapath.
package ptt_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int SLOT_W    = 4;
	localparam int TIME_W    = 32;
	localparam int RUNS_W    = 8;
	localparam int SIDX_W    = 8;
	localparam int ERR_W     = 2;

	typedef enum logic [1:0] {
		FUNC_ADD      = 2'd0,
		FUNC_TICK     = 2'd1,
		FUNC_DISPATCH = 2'd2,
		FUNC_DELETE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_TOO_MANY  = 2'd1,
		ERR_NO_DELETE = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_DEL,
		ST_TICK,
		ST_DISP,
		ST_NULL
	} state_t;

	typedef struct packed {
		logic latch;
		logic idx_clr;
		logic idx_inc;
		logic do_add;
		logic do_del;
		logic do_tick;
		logic do_disp;
		logic do_null;
	} ptt_cmd_t;

	typedef struct packed {
		logic slots_zero;
		logic tick_last;
		logic cur_ready;
		logic disp_last;
		logic any_ready;
		logic emit_ok;
	} ptt_sts_t;

endpackage

// ===== src/ptt_ctrl.sv =====
// Controller for the periodic task timer table.
// Sequences add, delete, tick walks and dispatch walks; depends on ptt_pkg.
module ptt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  ptt_pkg::ptt_sts_t   sts,
	output ptt_pkg::ptt_cmd_t   cmd
);

	ptt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ptt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch   = 1'b1;
					cmd.idx_clr = 1'b1;
					case (ptt_pkg::func_t'(func))
						ptt_pkg::FUNC_ADD:      state_d = ptt_pkg::ST_ADD;
						ptt_pkg::FUNC_TICK:     state_d = ptt_pkg::ST_TICK;
						ptt_pkg::FUNC_DISPATCH: state_d = sts.any_ready ? ptt_pkg::ST_DISP
						                                                : ptt_pkg::ST_NULL;
						ptt_pkg::FUNC_DELETE:   state_d = ptt_pkg::ST_DEL;
						default:                state_d = ptt_pkg::ST_IDLE;
					endcase
				end
			end
			ptt_pkg::ST_ADD: begin
				if (sts.emit_ok) begin
					cmd.do_add = 1'b1;
					state_d    = ptt_pkg::ST_IDLE;
				end
			end
			ptt_pkg::ST_DEL: begin
				if (sts.emit_ok) begin
					cmd.do_del = 1'b1;
					state_d    = ptt_pkg::ST_IDLE;
				end
			end
			ptt_pkg::ST_TICK: begin
				if (sts.slots_zero) begin
					state_d = ptt_pkg::ST_IDLE;
				end else begin
					cmd.do_tick = 1'b1;
					if (sts.tick_last) begin
						state_d = ptt_pkg::ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ptt_pkg::ST_DISP: begin
				// A slot without pending runs is passed over; a ready one waits for
				// room in the output register.
				if (!sts.cur_ready) begin
					cmd.idx_inc = 1'b1;
				end else if (sts.emit_ok) begin
					cmd.do_disp = 1'b1;
					if (sts.disp_last) begin
						state_d = ptt_pkg::ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ptt_pkg::ST_NULL: begin
				if (sts.emit_ok) begin
					cmd.do_null = 1'b1;
					state_d     = ptt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/ptt_dp.sv =====
// Datapath for the periodic task timer table.
// Holds the slot table, walk index, error register and output register; depends on ptt_pkg.
module ptt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ptt_pkg::ptt_cmd_t                   cmd,
	output ptt_pkg::ptt_sts_t                   sts,
	input  logic [ptt_pkg::TIME_W-1:0]          start_delay,
	input  logic [ptt_pkg::TIME_W-1:0]          repeat_period,
	input  logic                                has_handler,
	input  logic [ptt_pkg::SIDX_W-1:0]          slot_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ptt_pkg::SLOT_W-1:0]          task_slot,
	output logic                                run_valid,
	output logic [ptt_pkg::ERR_W-1:0]           status,
	output logic                                last
);

	// Slot table; entries at or above the fill count are never read.
	logic                        active_q [ptt_pkg::MAX_TASKS];
	logic [ptt_pkg::TIME_W-1:0]  delay_q  [ptt_pkg::MAX_TASKS];
	logic [ptt_pkg::TIME_W-1:0]  period_q [ptt_pkg::MAX_TASKS];
	logic [ptt_pkg::RUNS_W-1:0]  pend_q   [ptt_pkg::MAX_TASKS];

	// One bit per slot mirroring a nonzero pending-run count.
	logic [ptt_pkg::MAX_TASKS-1:0] ready_q;
	logic [ptt_pkg::CNT_W-1:0]     used_q;
	logic [ptt_pkg::ERR_W-1:0]     err_q;
	logic [ptt_pkg::IDX_W-1:0]     idx_q;

	logic [ptt_pkg::TIME_W-1:0]    new_delay_q;
	logic [ptt_pkg::TIME_W-1:0]    new_period_q;
	logic                          new_active_q;
	logic [ptt_pkg::SIDX_W-1:0]    sidx_q;

	logic                          out_valid_q;
	logic [ptt_pkg::SLOT_W-1:0]    slot_q;
	logic                          run_q;
	logic [ptt_pkg::ERR_W-1:0]     status_q;
	logic                          last_q;

	logic [ptt_pkg::IDX_W-1:0]     wr_idx;
	logic [ptt_pkg::IDX_W-1:0]     del_idx;
	logic                          add_ok;
	logic                          del_ok;
	logic                          cur_active;
	logic [ptt_pkg::TIME_W-1:0]    cur_delay;
	logic [ptt_pkg::TIME_W-1:0]    cur_period;
	logic [ptt_pkg::RUNS_W-1:0]    cur_pend;
	logic [ptt_pkg::MAX_TASKS-1:0] ready_above;
	logic                          emit;
	logic                          one_shot;

	assign wr_idx     = used_q[ptt_pkg::IDX_W-1:0];
	assign del_idx    = sidx_q[ptt_pkg::IDX_W-1:0];
	assign add_ok     = used_q < ptt_pkg::CNT_W'(ptt_pkg::MAX_TASKS);
	assign del_ok     = (sidx_q < ptt_pkg::SIDX_W'(used_q)) && active_q[del_idx];
	assign cur_active = active_q[idx_q];
	assign cur_delay  = delay_q[idx_q];
	assign cur_period = period_q[idx_q];
	assign cur_pend   = pend_q[idx_q];
	assign one_shot   = cur_period == '0;
	assign ready_above = (ready_q >> idx_q) >> 1;
	assign emit       = cmd.do_add | cmd.do_del | cmd.do_disp | cmd.do_null;

	assign sts.slots_zero = used_q == '0;
	assign sts.tick_last  = (ptt_pkg::CNT_W'(idx_q) + ptt_pkg::CNT_W'(1)) == used_q;
	assign sts.cur_ready  = ready_q[idx_q];
	assign sts.disp_last  = ready_above == '0;
	assign sts.any_ready  = ready_q != '0;
	assign sts.emit_ok    = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			new_delay_q  <= start_delay;
			new_period_q <= repeat_period;
			new_active_q <= has_handler;
			sidx_q       <= slot_index;
		end
		if (cmd.do_add && add_ok) begin
			active_q[wr_idx] <= new_active_q;
			delay_q[wr_idx]  <= new_delay_q;
			period_q[wr_idx] <= new_period_q;
			pend_q[wr_idx]   <= '0;
		end
		if (cmd.do_del && del_ok) begin
			active_q[del_idx] <= 1'b0;
			delay_q[del_idx]  <= '0;
			period_q[del_idx] <= '0;
			pend_q[del_idx]   <= '0;
		end
		if (cmd.do_tick && cur_active) begin
			if (cur_delay == '0) begin
				if (cur_pend != '1) begin
					pend_q[idx_q] <= cur_pend + ptt_pkg::RUNS_W'(1);
				end
				if (!one_shot) begin
					delay_q[idx_q] <= cur_period;
				end
			end else begin
				delay_q[idx_q] <= cur_delay - ptt_pkg::TIME_W'(1);
			end
		end
		if (cmd.do_disp) begin
			if (one_shot) begin
				active_q[idx_q] <= 1'b0;
				delay_q[idx_q]  <= '0;
				period_q[idx_q] <= '0;
				pend_q[idx_q]   <= '0;
			end else begin
				pend_q[idx_q] <= cur_pend - ptt_pkg::RUNS_W'(1);
			end
		end
		if (emit) begin
			if (cmd.do_disp) begin
				slot_q   <= ptt_pkg::SLOT_W'(idx_q);
				run_q    <= 1'b1;
				last_q   <= sts.disp_last;
				status_q <= one_shot ? ptt_pkg::ERR_NONE : err_q;
			end else if (cmd.do_del) begin
				slot_q   <= sidx_q[ptt_pkg::SLOT_W-1:0];
				run_q    <= 1'b0;
				last_q   <= 1'b1;
				status_q <= del_ok ? ptt_pkg::ERR_NONE : ptt_pkg::ERR_NO_DELETE;
			end else if (cmd.do_add && add_ok) begin
				slot_q   <= ptt_pkg::SLOT_W'(wr_idx);
				run_q    <= 1'b0;
				last_q   <= 1'b1;
				status_q <= err_q;
			end else if (cmd.do_add) begin
				slot_q   <= '0;
				run_q    <= 1'b0;
				last_q   <= 1'b1;
				status_q <= ptt_pkg::ERR_TOO_MANY;
			end else begin
				slot_q   <= '0;
				run_q    <= 1'b0;
				last_q   <= 1'b1;
				status_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q     <= '0;
			used_q      <= '0;
			err_q       <= ptt_pkg::ERR_NONE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + ptt_pkg::IDX_W'(1);
			end
			if (cmd.do_add) begin
				if (add_ok) begin
					ready_q[wr_idx] <= 1'b0;
					used_q          <= used_q + ptt_pkg::CNT_W'(1);
				end else begin
					err_q <= ptt_pkg::ERR_TOO_MANY;
				end
			end
			if (cmd.do_del) begin
				if (del_ok) begin
					ready_q[del_idx] <= 1'b0;
					err_q            <= ptt_pkg::ERR_NONE;
				end else begin
					err_q <= ptt_pkg::ERR_NO_DELETE;
				end
			end
			if (cmd.do_tick && cur_active && cur_delay == '0) begin
				ready_q[idx_q] <= 1'b1;
			end
			if (cmd.do_disp) begin
				ready_q[idx_q] <= !one_shot && (cur_pend != ptt_pkg::RUNS_W'(1));
				if (one_shot) begin
					err_q <= ptt_pkg::ERR_NONE;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign task_slot = slot_q;
	assign run_valid = run_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

// ===== src/periodic_task_timer_table.sv =====
// Periodic task timer table: sixteen task slots, each with a delay, a reload period, an active
// mark and a saturating pending-run count. The block takes one command beat at a time. An add
// or a delete gives one result beat. A tick walks the slots filled so far through a single
// read-modify-write port on the table, one slot a cycle, and gives no result. A dispatch walks
// the same way up to the last slot with pending runs and gives one beat per ready slot (or one
// null beat). A stalled output beat holds any command that has a beat to give until the output
// register frees. The next command is taken once the walk is over, while the final result may
// still wait in the output register.
module periodic_task_timer_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic [ptt_pkg::TIME_W-1:0]          start_delay,
	input  logic [ptt_pkg::TIME_W-1:0]          repeat_period,
	input  logic                                has_handler,
	input  logic [ptt_pkg::SIDX_W-1:0]          slot_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ptt_pkg::SLOT_W-1:0]          task_slot,
	output logic                                run_valid,
	output logic [ptt_pkg::ERR_W-1:0]           status,
	output logic                                last
);

	ptt_pkg::ptt_cmd_t cmd;
	ptt_pkg::ptt_sts_t sts;

	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_delay   (start_delay),
		.repeat_period (repeat_period),
		.has_handler   (has_handler),
		.slot_index    (slot_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.task_slot     (task_slot),
		.run_valid     (run_valid),
		.status        (status),
		.last          (last)
	);

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for periodic_task_timer_table: directed and random command beats,
// with a predictor of the task table and a queue of awaited result beats.
// Depends on ptt_pkg and the periodic_task_timer_table RTL.
module tb;

	typedef struct packed {
		logic [ptt_pkg::SLOT_W-1:0] slot;
		logic                       run;
		ptt_pkg::err_t              st;
		logic                       fin;
	} beat_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [1:0]                   func = ptt_pkg::FUNC_TICK;
	logic [ptt_pkg::TIME_W-1:0]   start_delay = '0;
	logic [ptt_pkg::TIME_W-1:0]   repeat_period = '0;
	logic                         has_handler = 1'b0;
	logic [ptt_pkg::SIDX_W-1:0]   slot_index = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [ptt_pkg::SLOT_W-1:0]   task_slot;
	logic                         run_valid;
	logic [ptt_pkg::ERR_W-1:0]    status;
	logic                         last;

	// Predicted table contents.
	logic                         slot_on   [ptt_pkg::MAX_TASKS];
	logic [ptt_pkg::TIME_W-1:0]   delay_cnt [ptt_pkg::MAX_TASKS];
	logic [ptt_pkg::TIME_W-1:0]   reload_cnt[ptt_pkg::MAX_TASKS];
	logic [ptt_pkg::RUNS_W-1:0]   runs_due  [ptt_pkg::MAX_TASKS];
	int                           filled = 0;
	ptt_pkg::err_t                err_now = ptt_pkg::ERR_NONE;

	beat_t                        beats_awaited[$];
	int                           mismatches = 0;
	logic                         quiet = 1'b0;

	periodic_task_timer_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.start_delay  (start_delay),
		.repeat_period(repeat_period),
		.has_handler  (has_handler),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.task_slot    (task_slot),
		.run_valid    (run_valid),
		.status       (status),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("mismatch: %s got %0d expected %0d", what, got, want);
	endtask

	task automatic clear_entry(int i);
		slot_on[i]    = 1'b0;
		delay_cnt[i]  = '0;
		reload_cnt[i] = '0;
		runs_due[i]   = '0;
	endtask

	// Advances the predicted table by one command and queues the beats it should give.
	task automatic step_timer_table(ptt_pkg::func_t f, logic [ptt_pkg::TIME_W-1:0] sd,
			logic [ptt_pkg::TIME_W-1:0] rp, logic hh, logic [ptt_pkg::SIDX_W-1:0] si);
		beat_t b;
		beat_t runs[$];
		case (f)
			ptt_pkg::FUNC_ADD: begin
				if (filled < ptt_pkg::MAX_TASKS) begin
					slot_on[filled]    = hh;
					delay_cnt[filled]  = sd;
					reload_cnt[filled] = rp;
					runs_due[filled]   = '0;
					b.slot = ptt_pkg::SLOT_W'(filled);
					filled++;
				end else begin
					err_now = ptt_pkg::ERR_TOO_MANY;
					b.slot = '0;
				end
				b.run = 1'b0;
				b.st  = err_now;
				b.fin = 1'b1;
				beats_awaited.push_back(b);
			end
			ptt_pkg::FUNC_TICK: begin
				for (int i = 0; i < filled; i++) begin
					if (slot_on[i]) begin
						if (delay_cnt[i] == 0) begin
							if (runs_due[i] != 8'hFF) runs_due[i]++;
							if (reload_cnt[i] != 0) delay_cnt[i] = reload_cnt[i];
						end else begin
							delay_cnt[i]--;
						end
					end
				end
			end
			ptt_pkg::FUNC_DISPATCH: begin
				for (int i = 0; i < filled; i++) begin
					if (runs_due[i] != 0) begin
						runs_due[i]--;
						// A one-shot task is removed once it has been run.
						if (reload_cnt[i] == 0) begin
							clear_entry(i);
							err_now = ptt_pkg::ERR_NONE;
						end
						b.slot = ptt_pkg::SLOT_W'(i);
						b.run  = 1'b1;
						b.st   = err_now;
						b.fin  = 1'b0;
						runs.push_back(b);
					end
				end
				if (runs.size() == 0) begin
					b.slot = '0;
					b.run  = 1'b0;
					b.st   = err_now;
					b.fin  = 1'b1;
					runs.push_back(b);
				end
				runs[runs.size() - 1].fin = 1'b1;
				foreach (runs[k]) beats_awaited.push_back(runs[k]);
			end
			ptt_pkg::FUNC_DELETE: begin
				if (si >= filled || !slot_on[si]) begin
					err_now = ptt_pkg::ERR_NO_DELETE;
				end else begin
					clear_entry(si);
					err_now = ptt_pkg::ERR_NONE;
				end
				b.slot = si[ptt_pkg::SLOT_W-1:0];
				b.run  = 1'b0;
				b.st   = err_now;
				b.fin  = 1'b1;
				beats_awaited.push_back(b);
			end
			default: begin
			end
		endcase
	endtask

	// Offers one command beat, waits for it to be taken, then predicts it.
	task automatic send_item(ptt_pkg::func_t f, logic [ptt_pkg::TIME_W-1:0] sd,
			logic [ptt_pkg::TIME_W-1:0] rp, logic hh, logic [ptt_pkg::SIDX_W-1:0] si);
		in_valid      <= 1'b1;
		func          <= f;
		start_delay   <= sd;
		repeat_period <= rp;
		has_handler   <= hh;
		slot_index    <= si;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		step_timer_table(f, sd, rp, hh, si);
		if (!quiet && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 6);
	end

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (beats_awaited.size() == 0) begin
				report_mismatch("result beat with nothing awaited, slot", task_slot, 0);
			end else begin
				want = beats_awaited.pop_front();
				if (task_slot !== want.slot) report_mismatch("task_slot", task_slot, want.slot);
				if (run_valid !== want.run) report_mismatch("run_valid", run_valid, want.run);
				if (status !== want.st) report_mismatch("status", status, want.st);
				if (last !== want.fin) report_mismatch("last", last, want.fin);
			end
		end
	end

	task automatic test_empty_table;
		send_item(ptt_pkg::FUNC_DELETE, '0, '0, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_DELETE, '1, '1, 1'b1, 8'd255);
		send_item(ptt_pkg::FUNC_DISPATCH, '0, '0, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_TICK, '1, '0, 1'b1, 8'd0);
		send_item(ptt_pkg::FUNC_DISPATCH, '0, '0, 1'b0, 8'd0);
	endtask

	task automatic test_first_tasks;
		send_item(ptt_pkg::FUNC_ADD, 32'd0, 32'd0, 1'b1, 8'd0);
		send_item(ptt_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);
		send_item(ptt_pkg::FUNC_ADD, 32'd1, 32'd1, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_TICK, '0, '0, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_DISPATCH, '0, '0, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_DISPATCH, '0, '0, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_DELETE, '0, '0, 1'b0, 8'd2);
		send_item(ptt_pkg::FUNC_DELETE, '0, '0, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_DELETE, '0, '0, 1'b0, 8'd1);
		send_item(ptt_pkg::FUNC_DELETE, '0, '0, 1'b0, 8'd3);
		send_item(ptt_pkg::FUNC_DELETE, '0, '0, 1'b0, 8'd16);
	endtask

	// A one-shot task with no delay gains a run on every tick; the count must stop at its top.
	task automatic test_run_count_saturation;
		send_item(ptt_pkg::FUNC_ADD, 32'd0, 32'd0, 1'b1, 8'd0);
		repeat (260) send_item(ptt_pkg::FUNC_TICK, $urandom, $urandom, 1'($urandom),
			8'($urandom));
		send_item(ptt_pkg::FUNC_DISPATCH, '0, '0, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_DISPATCH, '0, '0, 1'b0, 8'd0);
	endtask

	task automatic test_random_mix;
		int                         r;
		ptt_pkg::func_t             f;
		logic [ptt_pkg::TIME_W-1:0] sd;
		logic [ptt_pkg::TIME_W-1:0] rp;
		logic                       hh;
		logic [ptt_pkg::SIDX_W-1:0] si;
		for (int k = 0; k < 100; k++) begin
			quiet = (k >= 30 && k < 70);
			r  = $urandom_range(0, 99);
			sd = $urandom;
			rp = $urandom;
			hh = 1'($urandom);
			si = 8'($urandom);
			if (r < 12 && filled < ptt_pkg::MAX_TASKS) begin
				f  = ptt_pkg::FUNC_ADD;
				sd = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4);
				r  = $urandom_range(0, 7);
				rp = (r < 2) ? '0 : (r == 2) ? $urandom : $urandom_range(1, 4);
				hh = ($urandom_range(0, 9) != 0);
			end else if (r < 55) begin
				f = ptt_pkg::FUNC_TICK;
			end else if (r < 85) begin
				f = ptt_pkg::FUNC_DISPATCH;
			end else if (r < 91) begin
				f = ptt_pkg::FUNC_DELETE;
				if ($urandom_range(0, 3) != 0) si = 8'($urandom_range(0, filled));
			end else begin
				f = ptt_pkg::func_t'($urandom_range(0, 3));
			end
			send_item(f, sd, rp, hh, si);
		end
		quiet = 1'b0;
	endtask

	task automatic test_full_table;
		while (filled < ptt_pkg::MAX_TASKS) begin
			send_item(ptt_pkg::FUNC_ADD, $urandom_range(0, 3), $urandom_range(1, 3), 1'b1,
				8'd0);
		end
		repeat (3) send_item(ptt_pkg::FUNC_ADD, $urandom, $urandom, 1'($urandom), 8'($urandom));
		repeat (4) send_item(ptt_pkg::FUNC_TICK, $urandom, $urandom, 1'($urandom), 8'($urandom));
		send_item(ptt_pkg::FUNC_DISPATCH, '0, '0, 1'b0, 8'd0);
		send_item(ptt_pkg::FUNC_DELETE, '0, '0, 1'b0, 8'(ptt_pkg::MAX_TASKS - 1));
		send_item(ptt_pkg::FUNC_ADD, '1, '1, 1'b1, 8'd0);
	endtask

	initial begin
		for (int i = 0; i < ptt_pkg::MAX_TASKS; i++) clear_entry(i);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_first_tasks();
		test_run_count_saturation();
		test_random_mix();
		test_full_table();
		in_valid <= 1'b0;
		while (beats_awaited.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && beats_awaited.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
